@@ design/assert_macros.svh @@
// Assertion macros shared by the stack allocator modules.
// Each check is a clocked concurrent assertion with a reset disable; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/samr_pkg.sv @@
// Package for the stack allocator with mark and rewind.
// Holds field widths, operation and status codes, pool constants and the command struct.
package samr_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned NF_W   = 26;
  localparam int unsigned ST_W   = 3;

  localparam int unsigned POOL_BYTES  = 33554432;
  localparam int unsigned ALIGN_BYTES = 16;

  localparam int unsigned ALLOC_DEPTH_DEF = 128;
  localparam int unsigned MARK_DEPTH_DEF  = 16;

  localparam logic [FUNC_W-1:0] FN_ALLOC  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_MARK   = 2'd2;
  localparam logic [FUNC_W-1:0] FN_REWIND = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_SPACE  = 3'd1;
  localparam logic [ST_W-1:0] ST_FREE_IGN  = 3'd2;
  localparam logic [ST_W-1:0] ST_MARK_OVF  = 3'd3;
  localparam logic [ST_W-1:0] ST_REWIND_UF = 3'd4;

  typedef struct packed {
    logic capture;
    logic exec;
  } samr_cmd_t;

endpackage

@@ design/samr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the allocation stack and the mark stack.
module samr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/samr_ctrl.sv @@
// Controller for the stack allocator: request sequencing and result handshake.
// Depends on samr_pkg for the command struct.
`include "assert_macros.svh"

module samr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output samr_pkg::samr_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_tready   = (state_r == S_IDLE);
  assign cmd.capture = in_tvalid && in_tready;
  assign cmd.exec    = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign out_tvalid  = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.exec) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_IMPL(a_exec_has_room, clk, rst_n, cmd.exec, !out_valid_r || out_tready)
  `ASSERT_NEXT(a_exec_gives_result, clk, rst_n, cmd.exec, out_valid_r && state_r == S_IDLE)
  `ASSERT_NEXT(a_capture_starts_exec, clk, rst_n, cmd.capture, state_r == S_EXEC)

endmodule

@@ design/samr_dp.sv @@
// Datapath for the stack allocator: pointer, stack depths, stack memories and result register.
// Depends on samr_pkg and samr_ram.
`include "assert_macros.svh"

module samr_dp #(
  parameter int unsigned ALLOC_DEPTH = samr_pkg::ALLOC_DEPTH_DEF,
  parameter int unsigned MARK_DEPTH  = samr_pkg::MARK_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  samr_pkg::samr_cmd_t            cmd,
  input  logic [samr_pkg::FUNC_W-1:0]    req_func,
  input  logic [samr_pkg::NF_W-1:0]      req_size,
  input  logic [samr_pkg::NF_W-1:0]      req_address,
  output logic [samr_pkg::NF_W-1:0]      res_offset,
  output logic [samr_pkg::ST_W-1:0]      res_status,
  output logic                           res_tracked
);

  localparam int unsigned NF_W = samr_pkg::NF_W;
  localparam int unsigned ADW  = $clog2(ALLOC_DEPTH + 1);
  localparam int unsigned AAW  = (ALLOC_DEPTH > 1) ? $clog2(ALLOC_DEPTH) : 1;
  localparam int unsigned MDW  = $clog2(MARK_DEPTH + 1);
  localparam int unsigned MAW  = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
  localparam int unsigned MKW  = NF_W + ADW;

  localparam logic [NF_W-1:0] POOL       = NF_W'(samr_pkg::POOL_BYTES);
  localparam logic [NF_W:0]   ALIGN_ADD  = (NF_W + 1)'(samr_pkg::ALIGN_BYTES - 1);
  localparam logic [NF_W-1:0] ALIGN_MASK = ~(NF_W'(samr_pkg::ALIGN_BYTES - 1));

  logic [samr_pkg::FUNC_W-1:0] func_r;
  logic [NF_W-1:0]             size_r;
  logic [NF_W-1:0]             addr_r;

  logic [NF_W-1:0] next_free_r, next_free_nxt;
  logic [ADW-1:0]  alloc_depth_r, alloc_depth_nxt;
  logic [MDW-1:0]  mark_depth_r, mark_depth_nxt;

  logic [NF_W-1:0]          offset_r, offset_nxt;
  logic [samr_pkg::ST_W-1:0] status_r, status_nxt;
  logic                     tracked_r, tracked_nxt;

  logic [ADW-1:0]  alloc_dm1;
  logic [MDW-1:0]  mark_dm1;
  logic [NF_W-1:0] alloc_top;
  logic [MKW-1:0]  mark_top;
  logic [NF_W-1:0] space_left;
  logic [NF_W:0]   bump_sum;
  logic            alloc_push;
  logic            mark_push;

  assign alloc_dm1  = alloc_depth_r - ADW'(1);
  assign mark_dm1   = mark_depth_r - MDW'(1);
  assign space_left = (next_free_r < POOL) ? (POOL - next_free_r) : '0;
  assign bump_sum   = {1'b0, next_free_r} + {1'b0, size_r} + ALIGN_ADD;

  assign alloc_push = cmd.exec && (func_r == samr_pkg::FN_ALLOC) &&
                      (size_r <= space_left) && (alloc_depth_r < ADW'(ALLOC_DEPTH));
  assign mark_push  = cmd.exec && (func_r == samr_pkg::FN_MARK) &&
                      (mark_depth_r < MDW'(MARK_DEPTH));

  samr_ram #(.WIDTH(NF_W), .DEPTH(ALLOC_DEPTH)) u_alloc_ram (
    .clk     (clk),
    .wr_en   (alloc_push),
    .wr_addr (alloc_depth_r[AAW-1:0]),
    .wr_data (next_free_r),
    .rd_addr (alloc_dm1[AAW-1:0]),
    .rd_data (alloc_top)
  );

  samr_ram #(.WIDTH(MKW), .DEPTH(MARK_DEPTH)) u_mark_ram (
    .clk     (clk),
    .wr_en   (mark_push),
    .wr_addr (mark_depth_r[MAW-1:0]),
    .wr_data ({alloc_depth_r, next_free_r}),
    .rd_addr (mark_dm1[MAW-1:0]),
    .rd_data (mark_top)
  );

  always_comb begin
    next_free_nxt   = next_free_r;
    alloc_depth_nxt = alloc_depth_r;
    mark_depth_nxt  = mark_depth_r;
    offset_nxt      = '0;
    status_nxt      = samr_pkg::ST_OK;
    tracked_nxt     = 1'b0;
    case (func_r)
      samr_pkg::FN_ALLOC: begin
        if (size_r > space_left) begin
          status_nxt = samr_pkg::ST_NO_SPACE;
        end else begin
          if (alloc_depth_r < ADW'(ALLOC_DEPTH)) begin
            alloc_depth_nxt = alloc_depth_r + ADW'(1);
            tracked_nxt     = 1'b1;
          end
          offset_nxt    = next_free_r;
          next_free_nxt = bump_sum[NF_W-1:0] & ALIGN_MASK;
        end
      end
      samr_pkg::FN_FREE: begin
        if ((alloc_depth_r != '0) && (alloc_top == addr_r)) begin
          alloc_depth_nxt = alloc_dm1;
          next_free_nxt   = alloc_top;
        end else begin
          status_nxt = samr_pkg::ST_FREE_IGN;
        end
      end
      samr_pkg::FN_MARK: begin
        if (mark_depth_r >= MDW'(MARK_DEPTH)) begin
          status_nxt = samr_pkg::ST_MARK_OVF;
        end else begin
          mark_depth_nxt = mark_depth_r + MDW'(1);
        end
      end
      samr_pkg::FN_REWIND: begin
        if (mark_depth_r == '0) begin
          status_nxt = samr_pkg::ST_REWIND_UF;
        end else begin
          mark_depth_nxt  = mark_dm1;
          next_free_nxt   = mark_top[NF_W-1:0];
          alloc_depth_nxt = mark_top[NF_W +: ADW];
        end
      end
      default: status_nxt = samr_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= req_func;
      size_r <= req_size;
      addr_r <= req_address;
    end
    if (cmd.exec) begin
      offset_r  <= offset_nxt;
      status_r  <= status_nxt;
      tracked_r <= tracked_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r   <= '0;
      alloc_depth_r <= '0;
      mark_depth_r  <= '0;
    end else if (cmd.exec) begin
      next_free_r   <= next_free_nxt;
      alloc_depth_r <= alloc_depth_nxt;
      mark_depth_r  <= mark_depth_nxt;
    end
  end

  assign res_offset  = offset_r;
  assign res_status  = status_r;
  assign res_tracked = tracked_r;

  `ASSERT_ALWAYS(a_ptr_in_pool, clk, rst_n, next_free_r <= POOL)
  `ASSERT_ALWAYS(a_alloc_depth_max, clk, rst_n, alloc_depth_r <= ADW'(ALLOC_DEPTH))
  `ASSERT_ALWAYS(a_mark_depth_max, clk, rst_n, mark_depth_r <= MDW'(MARK_DEPTH))
  `ASSERT_NEXT(a_push_grows, clk, rst_n, alloc_push, alloc_depth_r == $past(alloc_depth_r) + ADW'(1))

endmodule

@@ design/stack_allocator_mark_rewind_core.sv @@
// Top level of the stack allocator with mark and rewind: stream ports, controller and datapath.
// Depends on samr_pkg, samr_ctrl, samr_dp and samr_ram.
//
//   Channel  Direction  Payload
//   in_*     input      tuser: func; tdata: size, address
//   out_*    output     tdata: offset; tuser: status, tracked
//
// Each transaction has a capture step, which reads both stack tops from their memories, and
// an update step, which updates the pointer and depths and loads the result register.
// A new transaction is accepted while a finished result waits on the output.
// The update step waits while the result register still holds an untaken result.
// Reset is synchronous and clears the pointer and both depths; the stacks need no clearing.
module stack_allocator_mark_rewind_core #(
  parameter int unsigned ALLOC_DEPTH = samr_pkg::ALLOC_DEPTH_DEF,
  parameter int unsigned MARK_DEPTH  = samr_pkg::MARK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // size [25:0], address [51:26], zero [55:52]
  input  logic [1:0]  in_tuser,   // func [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // offset [25:0], zero [31:26]
  output logic [3:0]  out_tuser   // status [2:0], tracked [3]
);

  localparam int unsigned NF_W = samr_pkg::NF_W;

  samr_pkg::samr_cmd_t       cmd;
  logic [NF_W-1:0]           res_offset;
  logic [samr_pkg::ST_W-1:0] res_status;
  logic                      res_tracked;

  samr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  samr_dp #(
    .ALLOC_DEPTH (ALLOC_DEPTH),
    .MARK_DEPTH  (MARK_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .req_func    (in_tuser),
    .req_size    (in_tdata[NF_W-1:0]),
    .req_address (in_tdata[2*NF_W-1:NF_W]),
    .res_offset  (res_offset),
    .res_status  (res_status),
    .res_tracked (res_tracked)
  );

  assign out_tdata = {6'd0, res_offset};
  assign out_tuser = {res_tracked, res_status};

endmodule
